>>> rtl/pdsma_pkg.sv
// Shared types, constants and the control program of the PD steering block.
`default_nettype none

package pdsma_pkg;

   localparam int unsigned SAMPLE_W   = 10;
   localparam int unsigned SPEED_W    = 9;
   localparam int unsigned BASE_W     = 8;
   localparam int unsigned GAIN_W     = 8;
   localparam int unsigned WIN_W      = 6;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned ERR_W      = 11;
   localparam int unsigned DIFF_W     = 12;
   localparam int unsigned PROD_W     = 20;
   localparam int unsigned ACC_W      = 21;
   localparam int unsigned CORR_W     = 10;
   localparam int unsigned STEP_W     = 4;

   localparam logic [SAMPLE_W-1:0] AVG_MAX = 10'd1023;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET      = 3'd4;

   // Register values after reset.
   localparam logic [BASE_W-1:0]   RST_BASE_SPEED = 8'd20;
   localparam logic [GAIN_W-1:0]   RST_GAIN_P     = 8'd1;
   localparam logic [GAIN_W-1:0]   RST_GAIN_D     = 8'd1;
   localparam logic [WIN_W-1:0]    RST_WINDOW     = 6'd15;
   localparam logic [SAMPLE_W-1:0] RST_TARGET     = 10'd155;

   typedef logic [STEP_W-1:0] step_type;

   // Program addresses.
   localparam step_type STEP_ACCEPT   = 4'd0;
   localparam step_type STEP_UPDATE   = 4'd1;
   localparam step_type STEP_DIV_INIT = 4'd2;
   localparam step_type STEP_DIV_BIT  = 4'd3;
   localparam step_type STEP_ERROR    = 4'd4;
   localparam step_type STEP_MUL_P    = 4'd5;
   localparam step_type STEP_MUL_D    = 4'd6;
   localparam step_type STEP_SUM      = 4'd7;
   localparam step_type STEP_OUTPUT   = 4'd8;
   localparam step_type STEP_RETURN   = 4'd9;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_UPDATE,
      OP_DIV_INIT,
      OP_DIV_BIT,
      OP_ERROR,
      OP_MUL_P,
      OP_MUL_D,
      OP_SUM,
      OP_OUTPUT
   } op_type;

   typedef enum logic [2:0] {
      JC_NONE,
      JC_ALWAYS,
      JC_NO_REQ,
      JC_DIV_MORE,
      JC_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     take;
   } ctl_type;

   // The control store: one word per step; a true condition jumps to target.
   function automatic ctl_type ucode(input step_type step);
      ctl_type c;
      c.op     = OP_NOP;
      c.cond   = JC_ALWAYS;
      c.target = STEP_ACCEPT;
      c.take   = 1'b0;
      unique case (step)
         STEP_ACCEPT: begin
            c.op     = OP_ACCEPT;
            c.cond   = JC_NO_REQ;
            c.target = STEP_ACCEPT;
            c.take   = 1'b1;
         end
         STEP_UPDATE: begin
            c.op   = OP_UPDATE;
            c.cond = JC_NONE;
         end
         STEP_DIV_INIT: begin
            c.op   = OP_DIV_INIT;
            c.cond = JC_NONE;
         end
         STEP_DIV_BIT: begin
            c.op     = OP_DIV_BIT;
            c.cond   = JC_DIV_MORE;
            c.target = STEP_DIV_BIT;
         end
         STEP_ERROR: begin
            c.op   = OP_ERROR;
            c.cond = JC_NONE;
         end
         STEP_MUL_P: begin
            c.op   = OP_MUL_P;
            c.cond = JC_NONE;
         end
         STEP_MUL_D: begin
            c.op   = OP_MUL_D;
            c.cond = JC_NONE;
         end
         STEP_SUM: begin
            c.op   = OP_SUM;
            c.cond = JC_NONE;
         end
         STEP_OUTPUT: begin
            c.op     = OP_OUTPUT;
            c.cond   = JC_OUT_BUSY;
            c.target = STEP_OUTPUT;
         end
         STEP_RETURN: begin
            c.op     = OP_NOP;
            c.cond   = JC_ALWAYS;
            c.target = STEP_ACCEPT;
         end
         default: begin
            c.op     = OP_NOP;
            c.cond   = JC_ALWAYS;
            c.target = STEP_ACCEPT;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/pd_steering_with_moving_average.sv
// Top level of the PD steering controller with a moving-average distance filter.
`default_nettype none

// One distance sample per word goes into a ring of RING_DEPTH entries; the
// running total over the ring, divided by the window length (truncated, held
// to 1023), is the average distance. The error against the target distance
// feeds a PD correction that is clamped and steers left and right speeds
// around the base speed. A small control program in a read-only table steps
// a datapath with one shared multiplier and a one-bit-per-cycle divider.
// Samples are taken one at a time: the program accepts a sample, updates the
// ring and total, runs the divider loop, one quotient bit per cycle over the
// TOTAL_W-bit total, then forms the error, the two products, the sum and the
// output before it returns to accept the next. A new sample is taken while
// the previous result still waits in the output register; the program holds
// at its output step only if that register is still full and stalled then.
// After reset the ring reads as zero through per-entry valid bits, so no
// clearing pass is needed.
module pd_steering_with_moving_average #(
   parameter int unsigned RING_DEPTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [pdsma_pkg::SAMPLE_W-1:0]  req_distance_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [pdsma_pkg::SPEED_W-1:0]   rsp_left_speed,
   output logic      [pdsma_pkg::SPEED_W-1:0]   rsp_right_speed,
   output logic      [pdsma_pkg::SAMPLE_W-1:0]  rsp_average_distance,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pdsma_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pdsma_pkg::CSR_DATA_W-1:0] csr_data
);

   import pdsma_pkg::*;

   localparam int unsigned SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int unsigned TOTAL_W = $clog2(RING_DEPTH * 1023 + 1);
   localparam int unsigned CNT_W   = $clog2(TOTAL_W + 1);

   // Configuration registers.
   logic        [BASE_W-1:0]   base_ff;
   logic signed [GAIN_W-1:0]   gain_p_ff;
   logic signed [GAIN_W-1:0]   gain_d_ff;
   logic        [WIN_W-1:0]    win_ff;
   logic        [SAMPLE_W-1:0] target_ff;

   // Sequencer.
   step_type step_ff, step_in;
   ctl_type  ctl;
   logic     jump;

   // Datapath state.
   logic        [RING_DEPTH-1:0] valid_ff, valid_in;
   logic                         valid_rd_ff, valid_rd_in;
   logic        [SLOT_W-1:0]     slot_ff, slot_in;
   logic        [TOTAL_W-1:0]    total_ff, total_in;
   logic        [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic        [TOTAL_W-1:0]    quo_ff, quo_in;
   logic        [WIN_W-1:0]      rem_ff, rem_in;
   logic        [CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic        [SAMPLE_W-1:0]   avg_ff, avg_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [ERR_W-1:0]      prev_err_ff, prev_err_in;
   logic signed [DIFF_W-1:0]     diff_ff, diff_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]  rsp_left_ff, rsp_left_in;
   logic [SPEED_W-1:0]  rsp_right_ff, rsp_right_in;
   logic [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;

   // Combinational helpers.
   logic                 accept;
   logic                 out_busy;
   logic [WIN_W-1:0]     win_eff;
   logic [SAMPLE_W-1:0]  ram_rd_data;
   logic [SAMPLE_W-1:0]  old_sample;
   logic                 ram_wr_en;
   logic [WIN_W:0]       rem_sh;
   logic signed [GAIN_W-1:0] mul_a;
   logic signed [DIFF_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_out;
   logic signed [ACC_W-1:0]  speed_wide;
   logic signed [CORR_W-1:0] corr;
   logic signed [CORR_W-1:0] speed_narrow;
   logic signed [CORR_W-1:0] left_full;
   logic signed [CORR_W-1:0] right_full;

   assign ctl       = ucode(step_ff);
   assign req_stall = !ctl.take;
   assign accept    = req_valid && ctl.take;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_left_speed       = rsp_left_ff;
   assign rsp_right_speed      = rsp_right_ff;
   assign rsp_average_distance = rsp_avg_ff;

   // A window of zero acts as one, and a window past the ring saturates.
   always_comb begin
      if (win_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (32'(win_ff) > RING_DEPTH) begin
         win_eff = WIN_W'(RING_DEPTH);
      end else begin
         win_eff = win_ff;
      end
   end

   assign old_sample = valid_rd_ff ? ram_rd_data : '0;
   assign ram_wr_en  = (ctl.op == OP_UPDATE);

   pdsma_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // The one multiplier, shared by the two gain steps.
   always_comb begin
      if (ctl.op == OP_MUL_D) begin
         mul_a = gain_d_ff;
         mul_b = diff_ff;
      end else begin
         mul_a = gain_p_ff;
         mul_b = DIFF_W'(err_ff);
      end
   end

   assign mul_out = mul_a * mul_b;

   // Clamp and steering, from the finished correction sum.
   assign speed_wide   = $signed({{(ACC_W - BASE_W){1'b0}}, base_ff});
   assign speed_narrow = $signed({{(CORR_W - BASE_W){1'b0}}, base_ff});

   always_comb begin
      if (acc_ff > speed_wide) begin
         corr = speed_narrow;
      end else if (acc_ff < -speed_wide) begin
         corr = -$signed({{(CORR_W - BASE_W + 1){1'b0}}, base_ff[BASE_W-1:1]});
      end else begin
         corr = CORR_W'(acc_ff);
      end
   end

   assign left_full  = speed_narrow - corr;
   assign right_full = speed_narrow + corr;

   assign rem_sh = {rem_ff, quo_ff[TOTAL_W-1]};

   always_comb begin
      unique case (ctl.cond)
         JC_NONE:     jump = 1'b0;
         JC_ALWAYS:   jump = 1'b1;
         JC_NO_REQ:   jump = !req_valid;
         JC_DIV_MORE: jump = (div_cnt_ff != CNT_W'(1));
         JC_OUT_BUSY: jump = out_busy;
         default:     jump = 1'b1;
      endcase
   end

   always_comb begin
      step_in      = jump ? ctl.target : step_ff + STEP_W'(1);
      valid_in     = valid_ff;
      valid_rd_in  = valid_rd_ff;
      slot_in      = slot_ff;
      total_in     = total_ff;
      sample_in    = sample_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      avg_in       = avg_ff;
      err_in       = err_ff;
      prev_err_in  = prev_err_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_avg_in   = rsp_avg_ff;

      case (ctl.op)
         OP_ACCEPT: begin
            if (accept) begin
               sample_in   = req_distance_sample;
               valid_rd_in = valid_ff[slot_ff];
            end
         end
         OP_UPDATE: begin
            total_in          = total_ff - TOTAL_W'(old_sample) + TOTAL_W'(sample_ff);
            valid_in[slot_ff] = 1'b1;
            if ((32'(slot_ff) + 32'd1) >= 32'(win_eff)) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         OP_DIV_INIT: begin
            quo_in     = total_ff;
            rem_in     = '0;
            div_cnt_in = CNT_W'(TOTAL_W);
         end
         OP_DIV_BIT: begin
            // Restoring division, one quotient bit per step.
            if (rem_sh >= {1'b0, win_eff}) begin
               rem_in = WIN_W'(rem_sh - {1'b0, win_eff});
               quo_in = {quo_ff[TOTAL_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[WIN_W-1:0];
               quo_in = {quo_ff[TOTAL_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - CNT_W'(1);
         end
         OP_ERROR: begin
            if (quo_ff > TOTAL_W'(AVG_MAX)) begin
               avg_in = AVG_MAX;
            end else begin
               avg_in = quo_ff[SAMPLE_W-1:0];
            end
            err_in      = $signed({1'b0, target_ff}) - $signed({1'b0, avg_in});
            diff_in     = DIFF_W'(err_in) - DIFF_W'(prev_err_ff);
            prev_err_in = err_in;
         end
         OP_MUL_P: begin
            prod_in = mul_out;
         end
         OP_MUL_D: begin
            acc_in  = ACC_W'(prod_ff);
            prod_in = mul_out;
         end
         OP_SUM: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
         OP_OUTPUT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = left_full[SPEED_W-1:0];
               rsp_right_in = right_full[SPEED_W-1:0];
               rsp_avg_in   = avg_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= RST_BASE_SPEED;
         gain_p_ff    <= RST_GAIN_P;
         gain_d_ff    <= RST_GAIN_D;
         win_ff       <= RST_WINDOW;
         target_ff    <= RST_TARGET;
         step_ff      <= STEP_ACCEPT;
         valid_ff     <= '0;
         slot_ff      <= '0;
         total_ff     <= '0;
         prev_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_SPEED: base_ff   <= csr_data[BASE_W-1:0];
               CSR_GAIN_P:     gain_p_ff <= $signed(csr_data[GAIN_W-1:0]);
               CSR_GAIN_D:     gain_d_ff <= $signed(csr_data[GAIN_W-1:0]);
               CSR_WINDOW:     win_ff    <= csr_data[WIN_W-1:0];
               CSR_TARGET:     target_ff <= csr_data[SAMPLE_W-1:0];
               default: begin
               end
            endcase
         end
         step_ff      <= step_in;
         valid_ff     <= valid_in;
         slot_ff      <= slot_in;
         total_ff     <= total_in;
         prev_err_ff  <= prev_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      valid_rd_ff  <= valid_rd_in;
      sample_ff    <= sample_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      avg_ff       <= avg_in;
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_avg_ff   <= rsp_avg_in;
   end

endmodule

`default_nettype wire

>>> rtl/pdsma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pdsma_ram #(
   parameter int unsigned WIDTH = 10,
   parameter int unsigned DEPTH = 32,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
